[rtl/ipte_pkg.sv]
// shared types and constants of the inverted page table engine
package ipte_pkg;

   // default number of physical frames
   localparam int unsigned PAGES_DEFAULT = 32;

   // field widths fixed by the interface
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned FRAME_W = 5;
   localparam int unsigned PID_W   = 8;
   localparam int unsigned VPAGE_W = 32;
   localparam int unsigned FREE_W  = 6;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 5;
   localparam int unsigned LFSR_W  = 16;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [FREE_W-1:0] FREE_MAX  = 6'd63;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPL_MODE  = 1'b1;

   // reset values of the registers
   localparam logic [4:0] PAGE_SHIFT_RESET = 5'd7;

   // replacement policies
   typedef enum logic [1:0] {
      REPL_NONE   = 2'd0,
      REPL_FIFO   = 2'd1,
      REPL_RANDOM = 2'd2,
      REPL_RSVD   = 2'd3
   } repl_type;

   // commands
   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 3'd0,
      CMD_ALLOC  = 3'd1,
      CMD_EVICT  = 3'd2,
      CMD_WRITE  = 3'd3,
      CMD_REMOVE = 3'd4,
      CMD_COUNT  = 3'd5,
      CMD_READ   = 3'd6,
      CMD_NOP    = 3'd7
   } cmd_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_SCAN,
      ST_MOD,
      ST_FIFO_RD,
      ST_FIFO_DATA,
      ST_TBL_DATA,
      ST_READ_DATA,
      ST_DONE
   } state_type;

   // one table word
   typedef struct packed {
      logic                read_only;
      logic                in_use;
      logic                dirty;
      logic                valid;
      logic [PID_W-1:0]    owner;
      logic [VPAGE_W-1:0]  vpage;
   } tbl_type;

   // one result beat
   typedef struct packed {
      logic                found;
      logic [FRAME_W-1:0]  frame;
      logic [FREE_W-1:0]   free_count;
      logic [VPAGE_W-1:0]  entry_vpage;
      logic [PID_W-1:0]    entry_pid;
      logic                entry_valid;
      logic                entry_dirty;
      logic                entry_use;
      logic                entry_read_only;
      logic                write_back;
   } rsp_type;

endpackage

[rtl/ipte_if.sv]
// request and response channel interfaces
interface ipte_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] vaddr;
   logic [7:0]  process_id;
   logic [4:0]  entry;
   logic [31:0] new_vpage;
   logic        new_valid;
   logic        new_dirty;
   logic        new_use;
   logic        new_read_only;

   modport source (output valid, cmd, vaddr, process_id, entry, new_vpage, new_valid,
                   new_dirty, new_use, new_read_only, input ready);
   modport sink   (input valid, cmd, vaddr, process_id, entry, new_vpage, new_valid,
                   new_dirty, new_use, new_read_only, output ready);
endinterface

interface ipte_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [4:0]  frame;
   logic [5:0]  free_count;
   logic [31:0] entry_vpage;
   logic [7:0]  entry_pid;
   logic        entry_valid;
   logic        entry_dirty;
   logic        entry_use;
   logic        entry_read_only;
   logic        write_back;

   modport source (output valid, found, frame, free_count, entry_vpage, entry_pid,
                   entry_valid, entry_dirty, entry_use, entry_read_only, write_back,
                   input ready);
   modport sink   (input valid, found, frame, free_count, entry_vpage, entry_pid,
                   entry_valid, entry_dirty, entry_use, entry_read_only, write_back,
                   output ready);
endinterface

[rtl/ipte_ram.sv]
// generic simple dual port ram with registered read
module ipte_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/inverted_page_table_engine.sv]
// Inverted page table engine: one command per request beat, one response beat each.
// Entries live in a table ram with registered read, allocation order in a fifo ram.
// Write answers from idle, read after a table read; allocate walks the allocated map
// one frame a cycle; lookup, purge, free count and random eviction stream the table
// ram one entry a cycle (random eviction first finds its start frame by a quotient
// step, then a remainder step); fifo eviction reads a fifo slot, then its table entry,
// per slot tried. A new request is taken while the previous response still waits.
module inverted_page_table_engine
   import ipte_pkg::*;
#(
   parameter int unsigned PAGES = PAGES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   ipte_req_if.sink              req_chan,
   ipte_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned IW = $clog2(PAGES);
   localparam int unsigned CW = $clog2(PAGES + 1);
   localparam int unsigned TW = $bits(tbl_type);
   localparam logic [IW-1:0] LAST = IW'(PAGES - 1);
   localparam logic [CW-1:0] FULL = CW'(PAGES);
   localparam logic [63:0] RECIP_W = ((64'd1 << 32) + 64'(PAGES) - 64'd1) / 64'(PAGES);
   localparam logic [31:0] RECIP = RECIP_W[31:0];

   state_type state_ff, state_in;
   logic [CMD_W-1:0]   op_ff, op_in;
   logic [PID_W-1:0]   pid_ff, pid_in;
   logic [VPAGE_W-1:0] vp_ff, vp_in;
   logic [IW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               dv_ff, dv_in;
   logic [IW-1:0]      daddr_ff, daddr_in;
   logic [CW-1:0]      nfree_ff, nfree_in;
   logic [LFSR_W-1:0]  div_ff, div_in;
   logic               step_ff, step_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PAGES-1:0]   alloc_ff, alloc_in;
   logic [PAGES-1:0]   written_ff, written_in;
   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      level_ff, level_in;
   logic [LFSR_W-1:0]  lfsr_ff, lfsr_in;
   logic [4:0]         page_shift_ff, page_shift_in;
   logic [1:0]         mode_ff, mode_in;

   // ram ports
   logic          tbl_we;
   logic [IW-1:0] tbl_waddr, tbl_raddr;
   tbl_type       tbl_wdata, tbl_q, ent_v;
   logic [TW-1:0] tbl_q_raw;
   logic          fifo_we;
   logic [IW-1:0] fifo_waddr, fifo_raddr, fifo_wdata, fifo_q;

   // helpers
   logic          ent_ok;
   logic          evictable;
   logic [47:0]   quot_prod;
   logic [31:0]   rem_full;
   logic [31:0]   nfree32;
   logic [LFSR_W-1:0] lfsr_next;
   rsp_type       show;

   ipte_ram #(.WIDTH(TW), .DEPTH(PAGES)) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_q_raw)
   );

   ipte_ram #(.WIDTH(IW), .DEPTH(PAGES)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_addr (fifo_raddr),
      .rd_data (fifo_q)
   );

   // unwritten entries read as zero
   assign tbl_q     = tbl_type'(tbl_q_raw);
   assign ent_v     = written_ff[daddr_ff] ? tbl_q : '0;
   assign evictable = !ent_v.valid && !ent_v.in_use;
   assign ent_ok    = 32'(req_chan.entry) < 32'(PAGES);
   assign nfree32   = 32'(nfree_ff);
   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);

   // quotient by reciprocal, then remainder against the lfsr
   assign quot_prod = 48'(div_ff) * 48'(RECIP);
   assign rem_full  = 32'(lfsr_ff) - 32'(div_ff) * 32'(PAGES);

   // entry shown for read and eviction
   always_comb begin
      show                 = '0;
      show.found           = 1'b1;
      show.frame           = FRAME_W'(daddr_ff);
      show.entry_vpage     = ent_v.vpage;
      show.entry_pid       = ent_v.owner;
      show.entry_valid     = ent_v.valid;
      show.entry_dirty     = ent_v.dirty;
      show.entry_use       = ent_v.in_use;
      show.entry_read_only = ent_v.read_only;
   end

   // handshake outputs
   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.found           = rsp_ff.found;
   assign rsp_chan.frame           = rsp_ff.frame;
   assign rsp_chan.free_count      = rsp_ff.free_count;
   assign rsp_chan.entry_vpage     = rsp_ff.entry_vpage;
   assign rsp_chan.entry_pid       = rsp_ff.entry_pid;
   assign rsp_chan.entry_valid     = rsp_ff.entry_valid;
   assign rsp_chan.entry_dirty     = rsp_ff.entry_dirty;
   assign rsp_chan.entry_use       = rsp_ff.entry_use;
   assign rsp_chan.entry_read_only = rsp_ff.entry_read_only;
   assign rsp_chan.write_back      = rsp_ff.write_back;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         alloc_ff      <= '0;
         written_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         level_ff      <= '0;
         lfsr_ff       <= LFSR_SEED;
         page_shift_ff <= PAGE_SHIFT_RESET;
         mode_ff       <= REPL_FIFO;
         dv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         alloc_ff      <= alloc_in;
         written_ff    <= written_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         level_ff      <= level_in;
         lfsr_ff       <= lfsr_in;
         page_shift_ff <= page_shift_in;
         mode_ff       <= mode_in;
         dv_ff         <= dv_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      pid_ff   <= pid_in;
      vp_ff    <= vp_in;
      ptr_ff   <= ptr_in;
      cnt_ff   <= cnt_in;
      daddr_ff <= daddr_in;
      nfree_ff <= nfree_in;
      div_ff   <= div_in;
      step_ff  <= step_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pid_in        = pid_ff;
      vp_in         = vp_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      dv_in         = 1'b0;
      daddr_in      = daddr_ff;
      nfree_in      = nfree_ff;
      div_in        = div_ff;
      step_in       = step_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      alloc_in      = alloc_ff;
      written_in    = written_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      level_in      = level_ff;
      lfsr_in       = lfsr_ff;
      page_shift_in = page_shift_ff;
      mode_in       = mode_ff;
      tbl_we        = 1'b0;
      tbl_waddr     = daddr_ff;
      tbl_wdata     = ent_v;
      tbl_raddr     = ptr_ff;
      fifo_we       = 1'b0;
      fifo_waddr    = tail_ff;
      fifo_wdata    = ptr_ff;
      fifo_raddr    = head_ff;

      // response beat taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_PAGE_SHIFT: page_shift_in = csr_wdata;
            CSR_REPL_MODE:  mode_in       = csr_wdata[1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.cmd;
               pid_in   = req_chan.process_id;
               vp_in    = req_chan.vaddr >> page_shift_ff;
               ptr_in   = '0;
               cnt_in   = '0;
               nfree_in = '0;
               res_in   = '0;
               state_in = ST_DONE;
               case (cmd_type'(req_chan.cmd))
                  CMD_LOOKUP, CMD_REMOVE, CMD_COUNT: state_in = ST_SCAN;
                  CMD_ALLOC: state_in = ST_ALLOC;
                  CMD_EVICT: begin
                     if (mode_ff == REPL_FIFO) begin
                        cnt_in = level_ff;
                        if (level_ff != '0) begin
                           state_in = ST_FIFO_RD;
                        end
                     end else if (mode_ff == REPL_RANDOM) begin
                        lfsr_in  = lfsr_next;
                        div_in   = lfsr_next;
                        step_in  = 1'b0;
                        state_in = ST_MOD;
                     end
                  end
                  CMD_WRITE: begin
                     if (ent_ok) begin
                        tbl_we              = 1'b1;
                        tbl_waddr           = IW'(req_chan.entry);
                        tbl_wdata.vpage     = req_chan.new_vpage;
                        tbl_wdata.owner     = req_chan.process_id;
                        tbl_wdata.valid     = req_chan.new_valid;
                        tbl_wdata.dirty     = req_chan.new_dirty;
                        tbl_wdata.in_use    = req_chan.new_use;
                        tbl_wdata.read_only = req_chan.new_read_only;
                        written_in[IW'(req_chan.entry)] = 1'b1;
                        res_in.found        = 1'b1;
                        res_in.frame        = req_chan.entry;
                     end
                  end
                  CMD_READ: begin
                     if (ent_ok) begin
                        tbl_raddr = IW'(req_chan.entry);
                        daddr_in  = IW'(req_chan.entry);
                        state_in  = ST_READ_DATA;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // lowest free frame, one map bit a cycle
         ST_ALLOC: begin
            if (!alloc_ff[ptr_ff]) begin
               alloc_in[ptr_ff] = 1'b1;
               if (level_ff != FULL) begin
                  fifo_we    = 1'b1;
                  fifo_wdata = ptr_ff;
                  tail_in    = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
                  level_in   = level_ff + 1'b1;
               end
               res_in.found = 1'b1;
               res_in.frame = FRAME_W'(ptr_ff);
               state_in     = ST_DONE;
            end else if (ptr_ff == LAST) begin
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // start frame of random eviction: quotient first, then remainder
         ST_MOD: begin
            if (!step_ff) begin
               div_in  = quot_prod[47:32];
               step_in = 1'b1;
            end else begin
               ptr_in   = rem_full[IW-1:0];
               state_in = ST_SCAN;
            end
         end

         // stream the table, one entry issued and one checked a cycle
         ST_SCAN: begin
            if (cnt_ff != FULL) begin
               tbl_raddr = ptr_ff;
               daddr_in  = ptr_ff;
               dv_in     = 1'b1;
               ptr_in    = (ptr_ff == LAST) ? '0 : ptr_ff + 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (dv_ff) begin
               case (cmd_type'(op_ff))
                  CMD_LOOKUP: begin
                     if (alloc_ff[daddr_ff] && ent_v.owner == pid_ff &&
                         ent_v.vpage == vp_ff) begin
                        res_in.found = 1'b1;
                        res_in.frame = FRAME_W'(daddr_ff);
                        state_in     = ST_DONE;
                     end
                  end
                  CMD_EVICT: begin
                     if (evictable) begin
                        res_in            = show;
                        res_in.write_back = ent_v.dirty;
                        state_in          = ST_DONE;
                     end
                  end
                  CMD_REMOVE: begin
                     if (ent_v.owner == pid_ff) begin
                        alloc_in[daddr_ff]   = 1'b0;
                        tbl_we               = 1'b1;
                        tbl_waddr            = daddr_ff;
                        tbl_wdata            = ent_v;
                        tbl_wdata.in_use     = 1'b0;
                        tbl_wdata.dirty      = 1'b0;
                        written_in[daddr_ff] = 1'b1;
                     end
                  end
                  CMD_COUNT: begin
                     if (!ent_v.in_use) begin
                        nfree_in = nfree_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end else if (cnt_ff == FULL) begin
               if (cmd_type'(op_ff) == CMD_COUNT) begin
                  res_in.free_count = (nfree32 > 32'(FREE_MAX)) ? FREE_MAX
                                                                : nfree32[FREE_W-1:0];
               end
               state_in = ST_DONE;
            end
         end

         // fifo eviction: read the head slot
         ST_FIFO_RD: begin
            fifo_raddr = head_ff;
            state_in   = ST_FIFO_DATA;
         end

         // rotate the head frame to the tail and fetch its entry
         ST_FIFO_DATA: begin
            fifo_we    = 1'b1;
            fifo_waddr = tail_ff;
            fifo_wdata = fifo_q;
            head_in    = (head_ff == LAST) ? '0 : head_ff + 1'b1;
            tail_in    = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
            cnt_in     = cnt_ff - 1'b1;
            tbl_raddr  = fifo_q;
            daddr_in   = fifo_q;
            state_in   = ST_TBL_DATA;
         end

         ST_TBL_DATA: begin
            fifo_raddr = head_ff;
            if (evictable) begin
               res_in            = show;
               res_in.write_back = ent_v.dirty;
               state_in          = ST_DONE;
            end else if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FIFO_DATA;
            end
         end

         ST_READ_DATA: begin
            res_in   = show;
            state_in = ST_DONE;
         end

         // hand over to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // fifo occupancy seen from the pointers
   logic [CW-1:0] fifo_span;
   assign fifo_span = (tail_ff >= head_ff) ? CW'(tail_ff - head_ff)
                                           : CW'(PAGES) - CW'(head_ff - tail_ff);

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= FULL)
      else $error("fifo level beyond frame count");

   a_level_span: assert property (@(posedge clock) disable iff (reset)
      (level_ff == FULL) || (level_ff == fifo_span))
      else $error("fifo level disagrees with head and tail");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != ST_IDLE))
      else $error("request beat taken without starting work");

   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("finished command produced no response beat");

endmodule

[tb/ipte_checker.sv]
// checker: watches the request and response channels, predicts and compares
`timescale 1ns / 1ps
module ipte_checker
   import ipte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ipte_req_if         req_chan,
   ipte_rsp_if         rsp_chan,
   input  logic        csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   localparam int NP = PAGES_DEFAULT;

   // shadow of the table and allocation state
   logic [31:0] sh_vpage [NP];
   logic [7:0]  sh_owner [NP];
   logic [3:0]  sh_flags [NP];
   logic [NP-1:0] sh_alloc;
   logic [4:0]  sh_slot [NP];
   int          sh_head, sh_tail, sh_level;
   logic [15:0] sh_lfsr;
   logic [4:0]  sh_shift;
   logic [1:0]  sh_mode;

   rsp_type expected_rsps[$];

   assign pending_count = expected_rsps.size();

   function automatic void push_slot(int f);
      if (sh_level >= NP) return;
      sh_slot[sh_tail] = f[4:0];
      sh_tail = (sh_tail + 1) % NP;
      sh_level++;
   endfunction

   function automatic bit can_evict(int f);
      return sh_flags[f][0] == 1'b0 && sh_flags[f][2] == 1'b0;
   endfunction

   function automatic void show(int f, ref rsp_type r);
      r.frame = f[4:0];
      r.entry_vpage = sh_vpage[f];
      r.entry_pid = sh_owner[f];
      r.entry_valid = sh_flags[f][0];
      r.entry_dirty = sh_flags[f][1];
      r.entry_use = sh_flags[f][2];
      r.entry_read_only = sh_flags[f][3];
   endfunction

   // work out the response to one request beat and update the shadow
   function automatic rsp_type predict_page_op(logic [2:0] cmd, logic [31:0] vaddr,
         logic [7:0] pid, logic [4:0] ent, logic [31:0] nvp, logic [3:0] nflags);
      rsp_type r;
      logic [31:0] vp;
      int f, n, c, start;
      bit hit;
      r = '0;
      hit = 0;
      f = 0;
      case (cmd)
         CMD_LOOKUP: begin
            vp = vaddr >> sh_shift;
            for (int i = 0; i < NP; i++)
               if (!r.found && sh_alloc[i] && sh_owner[i] == pid && sh_vpage[i] == vp) begin
                  r.found = 1'b1;
                  r.frame = i[4:0];
               end
         end
         CMD_ALLOC: begin
            for (int i = 0; i < NP; i++)
               if (!r.found && !sh_alloc[i]) begin
                  sh_alloc[i] = 1'b1;
                  push_slot(i);
                  r.found = 1'b1;
                  r.frame = i[4:0];
               end
         end
         CMD_EVICT: begin
            if (sh_mode == REPL_FIFO) begin
               n = sh_level;
               for (int i = 0; i < n && !hit; i++) begin
                  f = sh_slot[sh_head];
                  sh_head = (sh_head + 1) % NP;
                  sh_level--;
                  push_slot(f);
                  if (can_evict(f)) hit = 1;
               end
            end else if (sh_mode == REPL_RANDOM) begin
               if (sh_lfsr[0]) sh_lfsr = (sh_lfsr >> 1) ^ LFSR_TAPS;
               else sh_lfsr = sh_lfsr >> 1;
               start = sh_lfsr % NP;
               for (int i = 0; i < NP && !hit; i++) begin
                  f = (start + i) % NP;
                  if (can_evict(f)) hit = 1;
               end
            end
            if (hit) begin
               r.found = 1'b1;
               show(f, r);
               r.write_back = sh_flags[f][1];
            end
         end
         CMD_WRITE: begin
            sh_vpage[ent] = nvp;
            sh_owner[ent] = pid;
            sh_flags[ent] = nflags;
            r.found = 1'b1;
            r.frame = ent;
         end
         CMD_REMOVE: begin
            for (int i = 0; i < NP; i++)
               if (sh_owner[i] == pid) begin
                  sh_alloc[i] = 1'b0;
                  sh_flags[i] = sh_flags[i] & 4'b1001;
               end
         end
         CMD_COUNT: begin
            c = 0;
            for (int i = 0; i < NP; i++) if (!sh_flags[i][2]) c++;
            r.free_count = (c > 63) ? FREE_MAX : c[5:0];
         end
         CMD_READ: begin
            r.found = 1'b1;
            show(ent, r);
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         for (int i = 0; i < NP; i++) begin
            sh_vpage[i] = '0;
            sh_owner[i] = '0;
            sh_flags[i] = '0;
            sh_slot[i] = '0;
         end
         sh_alloc = '0;
         sh_head = 0;
         sh_tail = 0;
         sh_level = 0;
         sh_lfsr = LFSR_SEED;
         sh_shift = PAGE_SHIFT_RESET;
         sh_mode = REPL_FIFO;
         fail_count = 0;
         expected_rsps.delete();
      end else begin
         // response beat against the oldest expectation
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.found, rsp_chan.frame, rsp_chan.free_count,
                    rsp_chan.entry_vpage, rsp_chan.entry_pid, rsp_chan.entry_valid,
                    rsp_chan.entry_dirty, rsp_chan.entry_use, rsp_chan.entry_read_only,
                    rsp_chan.write_back};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, got);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display("%0t: response mismatch expected %h actual %h", $time, want, got);
                  fail_count++;
               end
            end
         end
         // request beat
         if (req_chan.valid && req_chan.ready)
            expected_rsps.push_back(predict_page_op(req_chan.cmd, req_chan.vaddr,
               req_chan.process_id, req_chan.entry, req_chan.new_vpage,
               {req_chan.new_read_only, req_chan.new_use, req_chan.new_dirty,
                req_chan.new_valid}));
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_PAGE_SHIFT) sh_shift = csr_wdata;
            else sh_mode = csr_wdata[1:0];
         end
      end
   end

endmodule

[tb/tb_top.sv]
// testbench top: clock, reset, stimulus phases and verdict
`timescale 1ns / 1ps
module tb_top;
   import ipte_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int fail_count, pending_count;
   int cycles = 0;
   int send_idle, recv_stall;
   logic written [32];
   int items_sent;

   ipte_req_if req_chan ();
   ipte_rsp_if rsp_chan ();

   inverted_page_table_engine i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ipte_checker i_checker (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver with random stall
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
   end

   // send one request beat, with random idle cycles before it
   task automatic send_beat(cmd_type cmd, logic [31:0] vaddr, logic [7:0] pid,
         logic [4:0] ent, logic [31:0] nvp, logic [3:0] nflags);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd <= cmd;
      req_chan.vaddr <= vaddr;
      req_chan.process_id <= pid;
      req_chan.entry <= ent;
      req_chan.new_vpage <= nvp;
      {req_chan.new_read_only, req_chan.new_use, req_chan.new_dirty,
       req_chan.new_valid} <= nflags;
      if (cmd == CMD_WRITE) written[ent] = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   // wait until idle, then write a register
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // random request, mostly on a small set of processes and pages
   task automatic random_beat(logic [4:0] shift);
      logic [2:0] c;
      logic [4:0] e;
      logic [7:0] pid;
      logic [31:0] vp;
      c = 3'($urandom_range(7));
      e = 5'($urandom_range(31));
      pid = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      vp = ($urandom_range(3) == 0) ? $urandom : $urandom_range(7);
      if (c == CMD_READ && !written[e]) c = CMD_WRITE;
      if (c == CMD_LOOKUP) begin
         // avoid comparing against never-written page numbers when allocated
         for (int i = 0; i < 32; i++) if (!written[i]) c = CMD_COUNT;
      end
      if (c == CMD_LOOKUP && $urandom_range(1))
         send_beat(CMD_LOOKUP, (vp << shift) | ($urandom & ((32'd1 << shift) - 1)),
                   pid, e, $urandom, 4'($urandom));
      else
         send_beat(cmd_type'(c), $urandom, pid, e, vp,
                   ($urandom_range(1)) ? 4'($urandom) : {2'($urandom), 2'b00});
   endtask

   initial begin
      logic [4:0] shifts [4];
      items_sent = 0;
      send_idle = 0;
      recv_stall = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_NOP;
      req_chan.vaddr = '0;
      req_chan.process_id = '0;
      req_chan.entry = '0;
      req_chan.new_vpage = '0;
      {req_chan.new_valid, req_chan.new_dirty, req_chan.new_use,
       req_chan.new_read_only} = '0;
      for (int i = 0; i < 32; i++) written[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: evict on empty, allocate all, full, extremes, purge
      send_beat(CMD_EVICT, 0, 0, 0, 0, 0);
      send_beat(CMD_COUNT, 0, 0, 0, 0, 0);
      for (int i = 0; i < 32; i++)
         send_beat(CMD_WRITE, 0, 8'(i % 3), 5'(i), 32'(i), 4'b0000);
      for (int i = 0; i < 33; i++) send_beat(CMD_ALLOC, 0, 0, 0, 0, 0);
      send_beat(CMD_WRITE, 0, 8'hFF, 5'd31, 32'hFFFF_FFFF, 4'b1111);
      send_beat(CMD_READ, 0, 0, 5'd31, 0, 0);
      send_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 0, 0, 0);
      send_beat(CMD_LOOKUP, 32'h0000_0100, 8'd2, 0, 0, 0);
      send_beat(CMD_EVICT, 0, 0, 0, 0, 0);
      send_beat(CMD_REMOVE, 0, 8'd1, 0, 0, 0);
      send_beat(CMD_ALLOC, 0, 0, 0, 0, 0);
      send_beat(CMD_EVICT, 0, 0, 0, 0, 0);
      send_beat(CMD_NOP, 32'hFFFF_FFFF, 8'hFF, 5'd31, 32'hFFFF_FFFF, 4'b1111);
      send_beat(CMD_COUNT, 0, 0, 0, 0, 0);

      // random phases over register settings and idling mixes
      shifts = '{5'd0, 5'd16, 5'd7, 5'd3};
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 69; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 69; end
            default: begin send_idle = 38; recv_stall = 38; end
         endcase
         write_reg(CSR_PAGE_SHIFT, shifts[ph % 4]);
         write_reg(CSR_REPL_MODE, 5'(ph / 4));
         for (int k = 0; k < 95; k++) random_beat(shifts[ph % 4]);
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d requests over 16 phases of shift, replacement mode and idling",
               items_sent);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

[sim.f]
rtl/ipte_pkg.sv
rtl/ipte_if.sv
rtl/ipte_ram.sv
rtl/inverted_page_table_engine.sv
tb/ipte_checker.sv
tb/tb_top.sv
